// File: hdl/b64_pkg.sv
// shared types, codes and alphabet mapping functions for the base64url codec
`default_nettype none

package b64_pkg;

  // codec_mode register codes
  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  localparam int unsigned MAX_RES = 3;

  // held bits between items
  typedef struct packed {
    logic [5:0] bits;
    logic [2:0] cnt;
    logic       stopped;
  } b64_state_t;

  // results caused by one input item
  typedef struct packed {
    logic [1:0] num;
    logic [7:0] char2;
    logic [7:0] char1;
    logic [7:0] char0;
  } step_res_t;

  // sextet value to its alphabet character
  function automatic logic [7:0] sextet_to_ascii(input logic [5:0] v);
    logic [7:0] c;
    begin
      if (v < 6'd26) begin
        c = 8'h41 + {2'b00, v};
      end else if (v < 6'd52) begin
        c = 8'h61 + {2'b00, v - 6'd26};
      end else if (v < 6'd62) begin
        c = 8'h30 + {2'b00, v - 6'd52};
      end else if (v == 6'd62) begin
        c = 8'h2D;
      end else begin
        c = 8'h5F;
      end
      return c;
    end
  endfunction

  // alphabet character to {invalid, sextet}
  function automatic logic [6:0] ascii_to_sextet(input logic [7:0] c);
    logic [7:0] v;
    logic       bad;
    begin
      bad = 1'b0;
      v   = 8'h00;
      if (c inside {[8'h41:8'h5A]}) begin
        v = c - 8'h41;
      end else if (c inside {[8'h61:8'h7A]}) begin
        v = c - 8'h61 + 8'd26;
      end else if (c inside {[8'h30:8'h39]}) begin
        v = c - 8'h30 + 8'd52;
      end else if (c == 8'h2D) begin
        v = 8'd62;
      end else if (c == 8'h5F) begin
        v = 8'd63;
      end else begin
        bad = 1'b1;
      end
      return {bad, v[5:0]};
    end
  endfunction

endpackage

`default_nettype wire

// File: hdl/b64_step.sv
// combinational step: results and next held bits for one item
`default_nettype none

module b64_step
  import b64_pkg::*;
(
  input  logic       mode_i,
  input  b64_state_t state_i,
  input  logic [7:0] data_i,
  input  logic       last_i,
  output b64_state_t state_o,
  output step_res_t  res_o
);

  logic [2:0]  cnt_c;
  logic [5:0]  acc6;

  // encode path
  logic [13:0] acc_e;
  logic [3:0]  sh1;
  logic [13:0] shr_e1;
  logic [13:0] shr_e2;
  logic        two;
  logic [2:0]  rem_e;
  logic [5:0]  rembits_e;
  logic [5:0]  flush_w;
  logic        flush;

  // decode path
  logic [6:0]  lut;
  logic [11:0] acc_d;
  logic        big;
  logic [2:0]  rem_d;
  logic [11:0] shr_d;
  logic [5:0]  rembits_d;

  assign cnt_c = (state_i.cnt > 3'd6) ? 3'd6 : state_i.cnt;
  assign acc6  = state_i.bits & ((6'd1 << cnt_c) - 6'd1);

  assign acc_e     = {acc6, data_i};
  assign sh1       = {1'b0, cnt_c} + 4'd2;
  assign shr_e1    = acc_e >> sh1;
  assign two       = (cnt_c >= 3'd4);
  assign shr_e2    = acc_e >> (cnt_c - 3'd4);
  assign rem_e     = two ? (cnt_c - 3'd4) : (cnt_c + 3'd2);
  assign rembits_e = acc_e[5:0] & ((6'd1 << rem_e) - 6'd1);
  assign flush_w   = rembits_e << (3'd6 - rem_e);
  assign flush     = last_i && (rem_e != 3'd0);

  assign lut       = ascii_to_sextet(data_i);
  assign acc_d     = {acc6, lut[5:0]};
  assign big       = (cnt_c >= 3'd2);
  assign rem_d     = big ? (cnt_c - 3'd2) : (cnt_c + 3'd6);
  assign shr_d     = acc_d >> rem_d;
  assign rembits_d = acc_d[5:0] & ((6'd1 << rem_d) - 6'd1);

  always_comb begin
    state_o = state_i;
    res_o   = '0;
    if (mode_i == MODE_ENCODE) begin
      res_o.char0 = sextet_to_ascii(shr_e1[5:0]);
      res_o.char1 = two ? sextet_to_ascii(shr_e2[5:0]) : sextet_to_ascii(flush_w);
      res_o.char2 = sextet_to_ascii(flush_w);
      res_o.num   = 2'd1 + {1'b0, two} + {1'b0, flush};
      state_o.bits = rembits_e;
      state_o.cnt  = rem_e;
    end else if (!state_i.stopped) begin
      if (lut[6]) begin
        state_o.stopped = 1'b1;
      end else begin
        res_o.char0  = shr_d[7:0];
        res_o.num    = big ? 2'd1 : 2'd0;
        state_o.bits = rembits_d;
        state_o.cnt  = rem_d;
      end
    end
    // end of message clears everything held
    if (last_i) begin
      state_o = '0;
    end
  end

endmodule

`default_nettype wire

// File: hdl/base64url_codec.sv
// top level of the streaming base64url codec, unpadded, encode or decode
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+----------------------------------
//  s_axis   | in        | s_axis_tvalid/tready      | tdata = byte or char, tlast = msg end
//  m_axis   | out       | m_axis_tvalid/tready      | tdata = char or byte, tuser = item
//           |           |                           |   done, tlast = message done
//  cfg      | in        | cfg_valid/cfg_ready       | cfg_data = codec_mode
//
// an item is registered on input, then the step logic maps it combinationally
// and loads its results (zero to three) into the result group register
// the result group drains one transaction per cycle while m_axis_tready is high
// the next item moves into the group as the last result of the previous is taken
// reset clears the mode to encode and all held bits; cfg is ready only when idle
// a stall on m_axis holds the group and then the input register, then s_axis
`default_nettype none

module base64url_codec
  import b64_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,

  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_in
  input  logic       s_axis_tlast,

  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] data_out
  output logic       m_axis_tuser,   // [0] run_last
  output logic       m_axis_tlast,

  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_data_i
);

  // mode register
  logic       mode_q;

  // held bits between items
  b64_state_t st_q, st_d;

  // input register
  logic       in_valid_q;
  logic [7:0] in_data_q;
  logic       in_last_q;

  // result group register
  logic       grp_valid_q;
  logic [1:0] grp_num_q;
  logic [1:0] grp_idx_q;
  logic       grp_last_q;
  logic [7:0] grp_char_q [MAX_RES];

  step_res_t  res;
  logic       out_fire;
  logic       out_final;
  logic       grp_free;
  logic       item_move;
  logic       in_fire;
  logic       cfg_fire;

  b64_step u_step (
    .mode_i  (mode_q),
    .state_i (st_q),
    .data_i  (in_data_q),
    .last_i  (in_last_q),
    .state_o (st_d),
    .res_o   (res)
  );

  // handshake plumbing
  assign out_final = (grp_idx_q == (grp_num_q - 2'd1));
  assign out_fire  = m_axis_tvalid && m_axis_tready;
  assign grp_free  = !grp_valid_q || (m_axis_tready && out_final);
  assign item_move = in_valid_q && grp_free;
  assign s_axis_tready = !in_valid_q || item_move;
  assign in_fire   = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o = !in_valid_q && !grp_valid_q;
  assign cfg_fire  = cfg_valid_i && cfg_ready_o;

  assign m_axis_tvalid = grp_valid_q;
  assign m_axis_tdata  = grp_char_q[grp_idx_q];
  assign m_axis_tuser  = out_final;
  assign m_axis_tlast  = out_final && grp_last_q;

  // control and state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_ENCODE;
      st_q        <= '0;
      in_valid_q  <= 1'b0;
      grp_valid_q <= 1'b0;
      grp_num_q   <= 2'd0;
      grp_idx_q   <= 2'd0;
    end else begin
      if (cfg_fire) begin
        // any mode write drops whatever was held
        mode_q <= cfg_data_i;
        st_q   <= '0;
      end else if (item_move) begin
        st_q <= st_d;
      end

      if (in_fire) begin
        in_valid_q <= 1'b1;
      end else if (item_move) begin
        in_valid_q <= 1'b0;
      end

      if (item_move) begin
        // items with no result leave the group empty
        grp_valid_q <= (res.num != 2'd0);
        grp_num_q   <= res.num;
        grp_idx_q   <= 2'd0;
      end else if (out_fire) begin
        if (out_final) begin
          grp_valid_q <= 1'b0;
        end else begin
          grp_idx_q <= grp_idx_q + 2'd1;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_data_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
    if (item_move) begin
      grp_char_q[0] <= res.char0;
      grp_char_q[1] <= res.char1;
      grp_char_q[2] <= res.char2;
      grp_last_q    <= in_last_q;
    end
  end

`ifndef SYNTH
  // a loaded group always has something to send
  a_grp_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    grp_valid_q |-> (grp_num_q != 2'd0))
    else $error("result group valid with no results");

  // the read pointer stays inside the group
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    grp_valid_q |-> (grp_idx_q < grp_num_q))
    else $error("result index beyond group size");

  // a mode write leaves nothing held
  a_cfg_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_fire |=> (st_q.cnt == 3'd0) && !st_q.stopped && (mode_q == $past(cfg_data_i)))
    else $error("held state not cleared by mode write");

  // encoding never holds six or more bits
  a_enc_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_ENCODE) |-> (st_q.cnt <= 3'd5))
    else $error("encoder holds too many bits");

  // a held item is not overwritten while the group is busy
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !grp_free) |=> in_valid_q && $stable(in_data_q))
    else $error("input register lost an item");
`endif

endmodule

`default_nettype wire
